>>> sv/bcomp_pkg.sv
// shared constants and codes for the barometric compensation block
package bcomp_pkg;

	// register map, one register every eight bytes
	typedef enum logic [2:0] {
		REG_OFFSET    = 3'd0,
		REG_UNSIGNED  = 3'd1,
		REG_QUADRATIC = 3'd2,
		REG_TEMP      = 3'd3,
		REG_OSS       = 3'd4
	} reg_idx_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TEMP_ZERO = 2'd1,
		ST_PRES_ZERO = 2'd2
	} status_t;

	// polynomial constants
	localparam int          C_T_ROUND   = 8;
	localparam int          C_B6_OFS    = 4000;
	localparam int          C_B4_OFS    = 32768;
	localparam logic [15:0] C_B7_SCALE  = 16'd50000;
	localparam logic [31:0] C_B7_HI     = 32'h80000000;
	localparam int          C_P_K1      = 3038;
	localparam int          C_P_K2      = -7357;
	localparam int          C_P_K3      = 3791;
	localparam int          C_T_MAX     = 32767;
	localparam int          C_T_MIN     = -32768;
	localparam int          C_P_MAX     = 262143;

endpackage

>>> sv/bcomp_div.sv
// pipelined restoring unsigned divider, one quotient bit per stage
module bcomp_div #(
	parameter int W  = 32,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [W-1:0]  in_num,
	input  logic [W-1:0]  in_den,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [W-1:0]  out_quo,
	output logic [SW-1:0] out_side
);

	logic [W:0]    rem_s  [W];
	logic [W-1:0]  nq_s   [W];
	logic [W-1:0]  den_s  [W];
	logic [SW-1:0] side_s [W];
	logic [W-1:0]  vld_s;

	for (genvar g = 0; g < W; g++) begin : g_stage
		logic [W:0]    rem_prev, rem_sh, rem_sub;
		logic [W-1:0]  nq_prev, den_prev;
		logic [SW-1:0] side_prev;
		logic          v_prev;

		// previous stage or divider inputs
		if (g == 0) begin : g_first
			assign rem_prev  = '0;
			assign nq_prev   = in_num;
			assign den_prev  = in_den;
			assign side_prev = in_side;
			assign v_prev    = in_valid;
		end else begin : g_next
			assign rem_prev  = rem_s[g-1];
			assign nq_prev   = nq_s[g-1];
			assign den_prev  = den_s[g-1];
			assign side_prev = side_s[g-1];
			assign v_prev    = vld_s[g-1];
		end

		// shift in next dividend bit, trial subtract
		assign rem_sh  = {rem_prev[W-1:0], nq_prev[W-1]};
		assign rem_sub = rem_sh - {1'b0, den_prev};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			den_s[g]  <= den_prev;
			side_s[g] <= side_prev;
			if (rem_sh >= {1'b0, den_prev}) begin
				rem_s[g] <= rem_sub;
				nq_s[g]  <= {nq_prev[W-2:0], 1'b1};
			end else begin
				rem_s[g] <= rem_sh;
				nq_s[g]  <= {nq_prev[W-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_s[W-1];
	assign out_quo   = nq_s[W-1];
	assign out_side  = side_s[W-1];

endmodule

>>> sv/barometric_temp_pressure_compensation.sv
// top level: barometric temperature and pressure compensation pipeline
//
// Takes one temperature/pressure sample pair per clock cycle (busy is never
// raised) and returns one result per pair, strobed on result_valid for one
// cycle, in request order. The pipeline is made of the two bit-per-stage
// dividers (WORD_WIDTH stages each) plus fourteen arithmetic stages. The
// receiver cannot stall results. Calibration registers are read live by the
// pipeline and must only be written while no request is in flight.
module barometric_temp_pressure_compensation
	import bcomp_pkg::*;
#(
	parameter int WORD_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [15:0]        raw_temperature,
	input  logic [18:0]        raw_pressure,
	output logic               result_valid,
	output logic signed [15:0] temperature_tenths,
	output logic [17:0]        pressure_pa,
	output logic [1:0]         status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);

	localparam int W   = WORD_WIDTH;
	localparam int SW1 = W + 21;
	localparam int SW2 = 19;

	localparam logic signed [W-1:0] T_MAX = W'(C_T_MAX);
	localparam logic signed [W-1:0] T_MIN = W'(C_T_MIN);
	localparam logic signed [W-1:0] P_MAX = W'(C_P_MAX);
	localparam logic signed [W-1:0] K1    = W'(C_P_K1);
	localparam logic signed [W-1:0] K2    = W'(C_P_K2);
	localparam logic signed [W-1:0] K3    = W'(C_P_K3);

	// configuration registers
	logic [47:0] off_q, uns_q;
	logic [31:0] quad_q, temp_q;
	logic [1:0]  oss_q;
	reg_idx_t    idx;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign idx    = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			uns_q  <= '0;
			quad_q <= '0;
			temp_q <= '0;
			oss_q  <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_OFFSET:    off_q  <= pwdata[47:0];
				REG_UNSIGNED:  uns_q  <= pwdata[47:0];
				REG_QUADRATIC: quad_q <= pwdata[31:0];
				REG_TEMP:      temp_q <= pwdata[31:0];
				REG_OSS:       oss_q  <= pwdata[1:0];
				default:       ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (idx)
			REG_OFFSET:    prdata = {16'd0, off_q};
			REG_UNSIGNED:  prdata = {16'd0, uns_q};
			REG_QUADRATIC: prdata = {32'd0, quad_q};
			REG_TEMP:      prdata = {32'd0, temp_q};
			REG_OSS:       prdata = {62'd0, oss_q};
			default:       prdata = '0;
		endcase
	end

	// coefficients as words
	logic signed [W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = {{(W-16){off_q[47]}}, off_q[47:32]};
	assign ac2 = {{(W-16){off_q[31]}}, off_q[31:16]};
	assign ac3 = {{(W-16){off_q[15]}}, off_q[15:0]};
	assign ac4 = {{(W-16){1'b0}}, uns_q[47:32]};
	assign ac5 = {{(W-16){1'b0}}, uns_q[31:16]};
	assign ac6 = {{(W-16){1'b0}}, uns_q[15:0]};
	assign b1  = {{(W-16){quad_q[31]}}, quad_q[31:16]};
	assign b2  = {{(W-16){quad_q[15]}}, quad_q[15:0]};
	assign mc  = {{(W-16){temp_q[31]}}, temp_q[31:16]};
	assign md  = {{(W-16){temp_q[15]}}, temp_q[15:0]};

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14;
	logic d1_valid, d2_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
			{v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14} <= '0;
		end else begin
			v_s1  <= start;
			v_s2  <= v_s1;
			v_s3  <= d1_valid;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= d2_valid;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	// stage 1: raw temperature product
	logic signed [W-1:0] tprod_s1;
	logic [18:0]         up_s1;
	always_ff @(posedge clk) begin
		tprod_s1 <= ({{(W-16){1'b0}}, raw_temperature} - ac6) * ac5;
		up_s1    <= raw_pressure;
	end

	// stage 2: temperature divisor, magnitudes for the divider
	logic signed [W-1:0] x1t, tden, tnum;
	logic [W-1:0]        num_s2, den_s2;
	logic [SW1-1:0]      side_s2;
	assign x1t  = tprod_s1 >>> 15;
	assign tden = x1t + md;
	assign tnum = mc <<< 11;
	always_ff @(posedge clk) begin
		num_s2  <= tnum[W-1] ? -tnum : tnum;
		den_s2  <= tden[W-1] ? -tden : tden;
		side_s2 <= {tnum[W-1] ^ tden[W-1], x1t, up_s1, tden == '0};
	end

	logic [W-1:0]   quo1;
	logic [SW1-1:0] side1;
	bcomp_div #(.W(W), .SW(SW1)) u_tdiv (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s2), .in_num(num_s2), .in_den(den_s2), .in_side(side_s2),
		.out_valid(d1_valid), .out_quo(quo1), .out_side(side1)
	);

	// stage 3: b5, temperature, b6
	logic signed [W-1:0] q1, b5, tw, x1d;
	logic [15:0]         tsat;
	logic signed [W-1:0] b6_s3;
	logic [15:0]         tout_s3;
	logic [18:0]         up_s3;
	logic                tz_s3;
	assign x1d = side1[W+19:20];
	assign q1  = side1[SW1-1] ? -quo1 : quo1;
	assign b5  = x1d + q1;
	assign tw  = (b5 + W'(C_T_ROUND)) >>> 4;
	always_comb begin
		priority if (tw > T_MAX) begin
			tsat = T_MAX[15:0];
		end else if (tw < T_MIN) begin
			tsat = T_MIN[15:0];
		end else begin
			tsat = tw[15:0];
		end
	end
	always_ff @(posedge clk) begin
		b6_s3   <= b5 - W'(C_B6_OFS);
		tout_s3 <= tsat;
		up_s3   <= side1[19:1];
		tz_s3   <= side1[0];
	end

	// stage 4: products of b6
	logic signed [W-1:0] sqp_s4, a2p_s4, a3p_s4;
	logic [15:0]         tout_s4;
	logic [18:0]         up_s4;
	logic                tz_s4;
	always_ff @(posedge clk) begin
		sqp_s4  <= b6_s3 * b6_s3;
		a2p_s4  <= ac2 * b6_s3;
		a3p_s4  <= ac3 * b6_s3;
		tout_s4 <= tout_s3;
		up_s4   <= up_s3;
		tz_s4   <= tz_s3;
	end

	// stage 5: scaled terms
	logic signed [W-1:0] sq_s5, x2a_s5, x1c_s5;
	logic [15:0]         tout_s5;
	logic [18:0]         up_s5;
	logic                tz_s5;
	always_ff @(posedge clk) begin
		sq_s5   <= sqp_s4 >>> 12;
		x2a_s5  <= a2p_s4 >>> 11;
		x1c_s5  <= a3p_s4 >>> 13;
		tout_s5 <= tout_s4;
		up_s5   <= up_s4;
		tz_s5   <= tz_s4;
	end

	// stage 6: quadratic products
	logic signed [W-1:0] b2sq_s6, b1sq_s6, x2a_s6, x1c_s6;
	logic [15:0]         tout_s6;
	logic [18:0]         up_s6;
	logic                tz_s6;
	always_ff @(posedge clk) begin
		b2sq_s6 <= b2 * sq_s5;
		b1sq_s6 <= b1 * sq_s5;
		x2a_s6  <= x2a_s5;
		x1c_s6  <= x1c_s5;
		tout_s6 <= tout_s5;
		up_s6   <= up_s5;
		tz_s6   <= tz_s5;
	end

	// stage 7: b3 and the b4 factor
	logic signed [W-1:0] x3a, b3o, x3b;
	logic signed [W-1:0] b3_s7, vv_s7;
	logic [15:0]         tout_s7;
	logic [18:0]         up_s7;
	logic                tz_s7;
	assign x3a = (b2sq_s6 >>> 11) + x2a_s6;
	assign b3o = (((ac1 <<< 2) + x3a) << oss_q) + W'(2);
	assign x3b = (x1c_s6 + (b1sq_s6 >>> 16) + W'(2)) >>> 2;
	always_ff @(posedge clk) begin
		b3_s7   <= b3o >>> 2;
		vv_s7   <= x3b + W'(C_B4_OFS);
		tout_s7 <= tout_s6;
		up_s7   <= up_s6;
		tz_s7   <= tz_s6;
	end

	// stage 8: b4 product, pressure difference
	logic signed [W-1:0] p4_s8, diff_s8;
	logic [15:0]         tout_s8;
	logic                tz_s8;
	always_ff @(posedge clk) begin
		p4_s8   <= ac4 * vv_s7;
		diff_s8 <= {{(W-19){1'b0}}, up_s7} - b3_s7;
		tout_s8 <= tout_s7;
		tz_s8   <= tz_s7;
	end

	// stage 9: b4 and b7
	logic [W-1:0] b4_s9, b7_s9;
	logic [15:0]  tout_s9;
	logic         tz_s9;
	always_ff @(posedge clk) begin
		b4_s9   <= p4_s8 >> 15;
		b7_s9   <= diff_s8 * {{(W-16){1'b0}}, C_B7_SCALE >> oss_q};
		tout_s9 <= tout_s8;
		tz_s9   <= tz_s8;
	end

	// stage 10: pressure divider inputs and status
	logic           b7_hi;
	status_t        st;
	logic [W-1:0]   num_s10, den_s10;
	logic [SW2-1:0] side_s10;
	assign b7_hi = b7_s9 >= {{(W-32){1'b0}}, C_B7_HI};
	always_comb begin
		priority if (tz_s9) begin
			st = ST_TEMP_ZERO;
		end else if (b4_s9 == '0) begin
			st = ST_PRES_ZERO;
		end else begin
			st = ST_OK;
		end
	end
	always_ff @(posedge clk) begin
		num_s10  <= b7_hi ? b7_s9 : (b7_s9 << 1);
		den_s10  <= b4_s9;
		side_s10 <= {b7_hi, tout_s9, st};
	end

	logic [W-1:0]   quo2;
	logic [SW2-1:0] side2;
	bcomp_div #(.W(W), .SW(SW2)) u_pdiv (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s10), .in_num(num_s10), .in_den(den_s10), .in_side(side_s10),
		.out_valid(d2_valid), .out_quo(quo2), .out_side(side2)
	);

	// stage 11: raw pressure and correction products
	logic signed [W-1:0] pq, pa;
	logic signed [W-1:0] p_s11, sqr_s11, m_s11;
	logic [17:0]         ts_s11;
	assign pq = side2[SW2-1] ? (quo2 << 1) : quo2;
	assign pa = pq >>> 8;
	always_ff @(posedge clk) begin
		p_s11   <= pq;
		sqr_s11 <= pa * pa;
		m_s11   <= K2 * pq;
		ts_s11  <= side2[17:0];
	end

	// stage 12: second-order term
	logic signed [W-1:0] p_s12, m2_s12, x2_s12;
	logic [17:0]         ts_s12;
	always_ff @(posedge clk) begin
		p_s12  <= p_s11;
		m2_s12 <= sqr_s11 * K1;
		x2_s12 <= m_s11 >>> 16;
		ts_s12 <= ts_s11;
	end

	// stage 13: corrected pressure
	logic signed [W-1:0] p_s13;
	logic [17:0]         ts_s13;
	always_ff @(posedge clk) begin
		p_s13  <= p_s12 + (((m2_s12 >>> 16) + x2_s12 + K3) >>> 4);
		ts_s13 <= ts_s12;
	end

	// stage 14: saturation and output register
	logic [17:0] psat;
	logic [15:0] tout_s14;
	logic [17:0] pout_s14;
	logic [1:0]  st_s14;
	always_comb begin
		priority if (p_s13[W-1]) begin
			psat = '0;
		end else if (p_s13 > P_MAX) begin
			psat = P_MAX[17:0];
		end else begin
			psat = p_s13[17:0];
		end
	end
	always_ff @(posedge clk) begin
		st_s14 <= ts_s13[1:0];
		if (status_t'(ts_s13[1:0]) == ST_OK) begin
			tout_s14 <= ts_s13[17:2];
			pout_s14 <= psat;
		end else begin
			tout_s14 <= '0;
			pout_s14 <= '0;
		end
	end

	assign result_valid       = v_s14;
	assign temperature_tenths = tout_s14;
	assign pressure_pa        = pout_s14;
	assign status             = st_s14;

endmodule

>>> test/barometric_temp_pressure_compensation_tb.sv
// testbench for the barometric compensation block: directed table, then random requests
module barometric_temp_pressure_compensation_tb
	import bcomp_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 2 * 32 + 14;
	localparam int DRAIN = LATENCY + 20;

	typedef struct packed {
		logic [15:0] temp;
		logic [17:0] pres;
		status_t     st;
	} reading_t;

	typedef struct packed {
		logic [47:0] offs;
		logic [47:0] uns;
		logic [31:0] quad;
		logic [31:0] tcoef;
		logic [1:0]  oss;
	} cal_t;

	typedef struct packed {
		logic [2:0]  cal_sel;
		logic [15:0] ut;
		logic [18:0] up;
		logic        typed;
		reading_t    want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [15:0] raw_temperature = '0;
	logic [18:0] raw_pressure = '0;
	logic result_valid;
	logic signed [15:0] temperature_tenths;
	logic [17:0] pressure_pa;
	logic [1:0] status;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	cal_t cal = '0;
	cal_t cal_sets [6];
	reading_t pending_readings [$];
	int mismatches = 0;

	barometric_temp_pressure_compensation DUT (.*);

	always #2 clk = ~clk;

	// word helpers at 32 bits, sign or zero extended to 64
	function automatic logic [63:0] sw(logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic logic [63:0] uw(logic [63:0] v);
		return {32'b0, v[31:0]};
	endfunction

	function automatic logic [63:0] asr(logic [63:0] v, int n);
		logic signed [63:0] s;
		s = sw(v);
		return sw(s >>> n);
	endfunction

	function automatic logic [63:0] sdiv(logic [63:0] a, logic [63:0] b);
		logic [63:0] ma, mb, q;
		a = sw(a);
		b = sw(b);
		ma = a[63] ? 64'd0 - a : a;
		mb = b[63] ? 64'd0 - b : b;
		q = ma / mb;
		return sw((a[63] != b[63]) ? 64'd0 - q : q);
	endfunction

	function automatic logic [63:0] sx16(logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// calibration polynomial for one sample pair
	function automatic reading_t compensate(logic [15:0] ut, logic [18:0] up);
		logic [63:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [63:0] x1, x2, x3, den, b5, b6, b3, b4, b7, sq, p, t;
		int oss;
		reading_t r;
		ac1 = sx16(cal.offs[47:32]);
		ac2 = sx16(cal.offs[31:16]);
		ac3 = sx16(cal.offs[15:0]);
		ac4 = {48'b0, cal.uns[47:32]};
		ac5 = {48'b0, cal.uns[31:16]};
		ac6 = {48'b0, cal.uns[15:0]};
		b1 = sx16(cal.quad[31:16]);
		b2 = sx16(cal.quad[15:0]);
		mc = sx16(cal.tcoef[31:16]);
		md = sx16(cal.tcoef[15:0]);
		oss = cal.oss;
		r = '{temp: '0, pres: '0, st: ST_OK};
		// temperature
		x1 = asr(({48'b0, ut} - ac6) * ac5, 15);
		den = sw(x1 + md);
		if (den == 64'd0) begin
			r.st = ST_TEMP_ZERO;
			return r;
		end
		x2 = sdiv(mc << 11, den);
		b5 = sw(x1 + x2);
		t = asr(b5 + 64'd8, 4);
		// pressure offset and scale
		b6 = sw(b5 - 64'd4000);
		sq = asr(b6 * b6, 12);
		x1 = asr(b2 * sq, 11);
		x2 = asr(ac2 * b6, 11);
		x3 = sw(x1 + x2);
		b3 = asr((uw(ac1 * 64'd4 + x3) << oss) + 64'd2, 2);
		x1 = asr(ac3 * b6, 13);
		x2 = asr(b1 * sq, 16);
		x3 = asr(x1 + x2 + 64'd2, 2);
		b4 = uw(ac4 * uw(x3 + 64'd32768)) >> 15;
		if (b4 == 64'd0) begin
			r.st = ST_PRES_ZERO;
			return r;
		end
		b7 = uw(({45'b0, up} - b3) * (64'd50000 >> oss));
		if (b7 < 64'h80000000)
			p = uw(b7 << 1) / b4;
		else
			p = uw((b7 / b4) << 1);
		p = sw(p);
		x1 = sw(asr(p, 8) * asr(p, 8));
		x1 = asr(x1 * 64'd3038, 16);
		x2 = asr((64'd0 - 64'd7357) * p, 16);
		p = sw(p + asr(x1 + x2 + 64'd3791, 4));
		// saturation
		if (t[63])
			r.temp = ((64'd0 - t) > 64'd32768) ? 16'h8000 : t[15:0];
		else
			r.temp = (t > 64'd32767) ? 16'h7FFF : t[15:0];
		if (p[63])
			r.pres = '0;
		else
			r.pres = (p > 64'd262143) ? 18'h3FFFF : p[17:0];
		return r;
	endfunction

	// register write: setup then access
	task automatic reg_write(int idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 6'(idx * 8);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_cal(cal_t c);
		reg_write(REG_OFFSET, {16'b0, c.offs});
		reg_write(REG_UNSIGNED, {16'b0, c.uns});
		reg_write(REG_QUADRATIC, {32'b0, c.quad});
		reg_write(REG_TEMP, {32'b0, c.tcoef});
		reg_write(REG_OSS, {62'b0, c.oss});
		// unmapped index, ignored
		reg_write(5, {$urandom, $urandom});
		cal = c;
	endtask

	// wait for all results, then past the pipeline
	task automatic drain();
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// one request; caller lowers start when it idles
	task automatic send_request(logic [15:0] ut, logic [18:0] up, logic typed, reading_t want);
		start <= 1'b1;
		raw_temperature <= ut;
		raw_pressure <= up;
		do @(posedge clk); while (busy);
		pending_readings.push_back(typed ? want : compensate(ut, up));
	endtask

	// result checker
	always @(posedge clk) begin
		reading_t w;
		if (arst_n && result_valid) begin
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result t=%0d p=%0d st=%0d",
						temperature_tenths, pressure_pa, status);
			end else begin
				w = pending_readings.pop_front();
				if (temperature_tenths !== w.temp || pressure_pa !== w.pres
						|| status !== w.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want t=%0d p=%0d st=%0d got t=%0d p=%0d st=%0d",
							$signed(w.temp), w.pres, w.st,
							temperature_tenths, pressure_pa, status);
				end
			end
		end
	end

	// timeout
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		row_t rows [$];
		reading_t tz, pz;
		cal_t typ, c;
		int cur, pct;
		logic [15:0] ut;
		logic [18:0] up;

		tz = '{temp: '0, pres: '0, st: ST_TEMP_ZERO};
		pz = '{temp: '0, pres: '0, st: ST_PRES_ZERO};
		typ = '{offs: {16'h0198, 16'hFFB8, 16'hC7D1}, uns: {16'h7FE5, 16'h7FF5, 16'h5A71},
			quad: {16'h182E, 16'h0004}, tcoef: {16'hDDF9, 16'h0B34}, oss: 2'd0};
		cal_sets[0] = '0;
		cal_sets[1] = typ;
		cal_sets[2] = typ;
		cal_sets[2].uns[47:32] = 16'h0000;
		cal_sets[3] = typ;
		cal_sets[3].oss = 2'd3;
		cal_sets[4] = typ;
		cal_sets[4].uns[31:16] = 16'h0000;
		cal_sets[4].tcoef[15:0] = 16'h0000;
		cal_sets[5] = '{offs: '1, uns: '1, quad: '1, tcoef: 32'h7FFF_8000, oss: 2'd2};

		// directed stimulus table
		rows.push_back('{0, 16'd0, 19'd0, 1'b1, tz});
		rows.push_back('{0, 16'hFFFF, 19'h7FFFF, 1'b1, tz});
		rows.push_back('{1, 16'd27898, 19'd23843, 1'b0, '0});
		rows.push_back('{1, 16'd0, 19'd0, 1'b0, '0});
		rows.push_back('{1, 16'hFFFF, 19'hFFFF, 1'b0, '0});
		rows.push_back('{1, 16'hFFFF, 19'd0, 1'b0, '0});
		rows.push_back('{1, 16'd0, 19'hFFFF, 1'b0, '0});
		rows.push_back('{2, 16'd27898, 19'd23843, 1'b1, pz});
		rows.push_back('{2, 16'hFFFF, 19'h7FFFF, 1'b1, pz});
		rows.push_back('{3, 16'd27898, 19'h7FFFF, 1'b0, '0});
		rows.push_back('{3, 16'd0, 19'h7FFFF, 1'b0, '0});
		rows.push_back('{3, 16'hFFFF, 19'd0, 1'b0, '0});
		rows.push_back('{4, 16'd27898, 19'd23843, 1'b1, tz});
		rows.push_back('{4, 16'hFFFF, 19'h7FFFF, 1'b1, tz});
		rows.push_back('{5, 16'd0, 19'h7FFFF, 1'b0, '0});
		rows.push_back('{5, 16'hFFFF, 19'd0, 1'b0, '0});
		rows.push_back('{5, 16'h8000, 19'h40000, 1'b0, '0});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur = 0;
		foreach (rows[i]) begin
			if (rows[i].cal_sel != cur) begin
				start <= 1'b0;
				drain();
				cur = rows[i].cal_sel;
				load_cal(cal_sets[cur]);
			end
			send_request(rows[i].ut, rows[i].up, rows[i].typed, rows[i].want);
		end

		// random phases, each with its own calibration and idling
		for (int ph = 0; ph < 6; ph++) begin
			start <= 1'b0;
			drain();
			case (ph % 3)
				0: begin
					c = typ;
					c.offs ^= 48'($urandom_range(0, 255));
					c.tcoef[15:0] = 16'($urandom_range(1000, 4000));
				end
				1: c = '{offs: 48'({$urandom, $urandom}), uns: 48'({$urandom, $urandom}),
					quad: $urandom, tcoef: $urandom, oss: '0};
				default: c = (ph == 2) ? cal_sets[5] : '0;
			endcase
			if (ph == 5)
				c.uns[47:32] = 16'h0001;
			c.oss = 2'(ph);
			load_cal(c);
			pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 66 : 21);
			for (int k = 0; k < 316; k++) begin
				if ($urandom_range(99) < 70) begin
					ut = 16'($urandom_range(20000, 36000));
					up = 19'($urandom_range(15000, 45000) << c.oss);
				end else begin
					ut = 16'($urandom);
					up = 19'($urandom);
				end
				send_request(ut, up, 1'b0, '0);
				// each cycle is idle with probability pct percent
				if ($urandom_range(99) < pct) begin
					start <= 1'b0;
					@(posedge clk);
					while ($urandom_range(99) < pct)
						@(posedge clk);
				end
			end
		end

		start <= 1'b0;
		drain();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> filelist.f
sv/bcomp_pkg.sv
sv/bcomp_div.sv
sv/barometric_temp_pressure_compensation.sv
test/barometric_temp_pressure_compensation_tb.sv
